// ===== src/ttdp_pkg.sv =====
`timescale 1ns / 1ps

package ttdp_pkg;

    localparam int INDEX_BITS    = 12;
    localparam int PAYLOAD_WIDTH = 48;
    localparam int KEY_WIDTH     = 64;
    localparam int DEPTH_WIDTH   = 8;
    localparam int SLOT_COUNT    = 1 << INDEX_BITS;
    localparam int COUNT_WIDTH   = INDEX_BITS + 1;
    localparam int CFG_WIDTH     = 4;

    typedef enum logic [1:0] {
        FN_PROBE = 2'd0,
        FN_STORE = 2'd1,
        FN_CLEAR = 2'd2
    } func_t;

    typedef enum logic {
        REG_TABLE_ENABLE = 1'b0,
        REG_INDEX_BITS   = 1'b1
    } cfg_reg_t;

    typedef logic [INDEX_BITS-1:0] slot_idx_t;

    typedef struct packed {
        func_t                    func;
        logic [KEY_WIDTH-1:0]     key;
        logic [DEPTH_WIDTH-1:0]   depth;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic [DEPTH_WIDTH-1:0]   found_depth;
        logic [PAYLOAD_WIDTH-1:0] found_payload;
        logic [COUNT_WIDTH-1:0]   occupied;
    } rsp_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]     key;
        logic [DEPTH_WIDTH-1:0]   depth;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } slot_t;

    // Index bits above INDEX_BITS saturate because every mask bit is then set.
    function automatic slot_idx_t slot_of(input logic [KEY_WIDTH-1:0] key,
                                          input logic [CFG_WIDTH-1:0] bits);
        slot_idx_t mask;
        for (int i = 0; i < INDEX_BITS; i++)
        begin
            mask[i] = (i < int'(bits));
        end
        return key[INDEX_BITS-1:0] & mask;
    endfunction

endpackage

// ===== src/transposition_table_depth_preferred.sv =====
`timescale 1ns / 1ps

// Direct-mapped, depth-preferred transposition table. Each request first reads
// the slot from the single-port-read slot memory, whose read data is registered,
// and then compares, writes back a store and registers the response. The
// response register lets the next request be accepted while a response still
// waits. After reset, after a clear request on an enabled table and after every
// write to index_bits the block wipes all 4096 slots, one slot per cycle, and
// holds req_ready low until the wipe ends; configuration writes are still
// taken then. The occupied count in every response is the count after the
// request.
module transposition_table_depth_preferred
    import ttdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  cfg_reg_t             cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    slot_idx_t              sweep_reg, sweep_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   enable_reg, enable_next;
    logic [CFG_WIDTH-1:0]   bits_reg, bits_next;
    req_t                   req_reg, req_next;
    rsp_t                   rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic      rd_en;
    slot_idx_t rd_addr;
    slot_t     rd_data;
    logic      wr_en;
    slot_idx_t wr_addr;
    slot_t     wr_data;

    logic                   look_go;
    logic                   key_eq;
    logic                   store_ok;
    logic                   probe_hit;
    logic                   do_clear;
    logic [COUNT_WIDTH-1:0] occ_after;

    ttdp_slot_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rd_en     = req_valid && req_ready;
    assign rd_addr   = slot_of(req.key, bits_reg);

    // The read data stays put while a finished response waits for the output.
    assign look_go   = (state_reg == ST_LOOK) && (!rsp_valid_reg || rsp_ready);
    assign key_eq    = (rd_data.key == req_reg.key);
    assign probe_hit = enable_reg && (req_reg.func == FN_PROBE) && key_eq
                       && (rd_data.depth >= req_reg.depth);
    assign store_ok  = enable_reg && (req_reg.func == FN_STORE)
                       && ((key_eq && (rd_data.depth < req_reg.depth))
                           || (rd_data.key == '0));
    assign do_clear  = enable_reg && (req_reg.func == FN_CLEAR);

    always_comb
    begin
        occ_after = count_reg;
        if (do_clear)
        begin
            occ_after = '0;
        end
        else if (store_ok && (rd_data.key == '0) && (req_reg.key != '0))
        begin
            occ_after = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = slot_of(req_reg.key, bits_reg);
        wr_data = '{key: req_reg.key, depth: req_reg.depth, payload: req_reg.payload};
        if (state_reg == ST_SWEEP)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_data = '0;
        end
        else if (look_go && store_ok)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        count_next     = count_reg;
        enable_next    = enable_reg;
        bits_next      = bits_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            ST_SWEEP:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (&sweep_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (look_go)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.hit           = probe_hit;
                    rsp_next.found_depth   = probe_hit ? rd_data.depth : '0;
                    rsp_next.found_payload = probe_hit ? rd_data.payload : '0;
                    rsp_next.occupied      = occ_after;
                    count_next             = occ_after;
                    if (do_clear)
                    begin
                        sweep_next = '0;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                sweep_next = '0;
                state_next = ST_SWEEP;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                REG_TABLE_ENABLE:
                begin
                    enable_next = cfg_data[0];
                end
                REG_INDEX_BITS:
                begin
                    // A resize empties the whole table.
                    bits_next  = cfg_data;
                    count_next = '0;
                    sweep_next = '0;
                    state_next = ST_SWEEP;
                end
                default:
                begin
                    enable_next = enable_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            count_reg     <= '0;
            enable_reg    <= 1'b1;
            bits_reg      <= CFG_WIDTH'(INDEX_BITS);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            count_reg     <= count_next;
            enable_reg    <= enable_next;
            bits_reg      <= bits_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/ttdp_slot_ram.sv =====
`timescale 1ns / 1ps

module ttdp_slot_ram
    import ttdp_pkg::*;
(
    input  logic      clk,
    input  logic      wr_en,
    input  slot_idx_t wr_addr,
    input  slot_t     wr_data,
    input  logic      rd_en,
    input  slot_idx_t rd_addr,
    output slot_t     rd_data
);

    slot_t mem [SLOT_COUNT];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== bench/ttdp_checker.sv =====
`timescale 1ns / 1ps

module ttdp_checker
    import ttdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  req_t                 req,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  rsp_t                 rsp,
    input  logic                 cfg_we,
    input  cfg_reg_t             cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    output int                   errors,
    output int                   pending
);

    logic [KEY_WIDTH-1:0]     slot_key     [SLOT_COUNT];
    logic [DEPTH_WIDTH-1:0]   slot_depth   [SLOT_COUNT];
    logic [PAYLOAD_WIDTH-1:0] slot_payload [SLOT_COUNT];
    logic [COUNT_WIDTH-1:0]   fill_count;
    logic                     table_on;
    logic [CFG_WIDTH-1:0]     size_log2;
    rsp_t                     owed_responses [$];
    rsp_t                     want;

    function automatic void empty_table();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_key[i]     = '0;
            slot_depth[i]   = '0;
            slot_payload[i] = '0;
        end
        fill_count = '0;
    endfunction

    // Applies one request to the table copy and returns the response it owes.
    function automatic rsp_t table_access(input req_t r);
        rsp_t                  o;
        int                    used;
        logic [INDEX_BITS-1:0] mask;
        logic [INDEX_BITS-1:0] s;
        o    = '0;
        used = (int'(size_log2) > INDEX_BITS) ? INDEX_BITS : int'(size_log2);
        mask = INDEX_BITS'((1 << used) - 1);
        s    = r.key[INDEX_BITS-1:0] & mask;
        if (table_on)
        begin
            case (r.func)
                FN_PROBE:
                begin
                    if (slot_key[s] == r.key && slot_depth[s] >= r.depth)
                    begin
                        o.hit           = 1'b1;
                        o.found_depth   = slot_depth[s];
                        o.found_payload = slot_payload[s];
                    end
                end
                FN_STORE:
                begin
                    // An empty slot takes any key; an occupied one only a deeper copy.
                    if (slot_key[s] == '0 || (slot_key[s] == r.key && slot_depth[s] < r.depth))
                    begin
                        if (slot_key[s] == '0 && r.key != '0)
                            fill_count = fill_count + 1'b1;
                        slot_key[s]     = r.key;
                        slot_depth[s]   = r.depth;
                        slot_payload[s] = r.payload;
                    end
                end
                FN_CLEAR:
                    empty_table();
                default:
                    ;
            endcase
        end
        o.occupied = fill_count;
        return o;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_table();
            table_on  = 1'b1;
            size_log2 = CFG_WIDTH'(INDEX_BITS);
            owed_responses.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed_responses.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: response with no request outstanding: %h", $time, rsp);
                end
                else
                begin
                    want = owed_responses.pop_front();
                    if (rsp.hit !== want.hit)
                        note_mismatch("hit", 64'(want.hit), 64'(rsp.hit));
                    if (rsp.found_depth !== want.found_depth)
                        note_mismatch("found_depth", 64'(want.found_depth),
                                      64'(rsp.found_depth));
                    if (rsp.found_payload !== want.found_payload)
                        note_mismatch("found_payload", 64'(want.found_payload),
                                      64'(rsp.found_payload));
                    if (rsp.occupied !== want.occupied)
                        note_mismatch("occupied", 64'(want.occupied), 64'(rsp.occupied));
                end
            end
            if (req_valid && req_ready)
                owed_responses.push_back(table_access(req));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TABLE_ENABLE:
                        table_on = cfg_data[0];
                    REG_INDEX_BITS:
                    begin
                        // Resizing reallocates the table, so every slot starts empty.
                        size_log2 = cfg_data;
                        empty_table();
                    end
                    default:
                        ;
                endcase
            end
            pending = owed_responses.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ttdp_pkg::*;

    localparam func_t FN_UNUSED = func_t'(2'd3);
    localparam int    WAIT_MAX  = 18;
    localparam int    POOL_SIZE = 16;

    localparam logic [KEY_WIDTH-1:0]     KEY_ALL  = '1;
    localparam logic [KEY_WIDTH-1:0]     KEY_ALIAS = 64'h0123_4567_89AB_CFFF;
    localparam logic [KEY_WIDTH-1:0]     KEY_LOW  = 64'h0000_0000_0000_1000;
    localparam logic [PAYLOAD_WIDTH-1:0] PAY_ALL  = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_t                 rsp;
    logic                 cfg_we;
    cfg_reg_t             cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;
    int                   errors;
    int                   pending;
    logic                 steady;
    logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];

    int phase_enable [12] = '{1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 1};
    int phase_bits   [12] = '{12, 1, 3, 15, 2, 0, 5, 13, 2, 8, 12, 4};

    always #4 clk = ~clk;

    transposition_table_depth_preferred uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ttdp_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        #12_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send(input func_t f, input logic [KEY_WIDTH-1:0] k,
                        input logic [DEPTH_WIDTH-1:0] d, input logic [PAYLOAD_WIDTH-1:0] p);
        int   gap;
        req_t r;
        gap       = steady ? 0 : $urandom_range(0, WAIT_MAX);
        r.func    = f;
        r.key     = k;
        r.depth   = d;
        r.payload = p;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Waits until every request has been answered; a clear may still be wiping.
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_WIDTH-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly reuses recent keys so that probes find what stores left behind.
    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int                   r;
        logic [KEY_WIDTH-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 2)
            return '0;
        if (r < 70)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        k = {$urandom(), $urandom()};
        if (r < 80)
            k[INDEX_BITS-1:0] = key_pool[$urandom_range(0, POOL_SIZE - 1)][INDEX_BITS-1:0];
        key_pool[$urandom_range(0, POOL_SIZE - 1)] = k;
        return k;
    endfunction

    function automatic logic [DEPTH_WIDTH-1:0] pick_depth();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return DEPTH_WIDTH'($urandom_range(0, 255));
    endfunction

    task automatic random_requests(input int n);
        int          c;
        func_t       f;
        logic [63:0] wide;
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(0, 199);
            if (c < 3)
                f = FN_CLEAR;
            else if (c < 8)
                f = FN_UNUSED;
            else if (c < 104)
                f = FN_PROBE;
            else
                f = FN_STORE;
            if ($urandom_range(0, 31) == 0)
                steady = ~steady;
            wide = {$urandom(), $urandom()};
            send(f, pick_key(), pick_depth(), wide[PAYLOAD_WIDTH-1:0]);
        end
    endtask

    initial
    begin
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = steady ? 0 : $urandom_range(0, WAIT_MAX);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_valid && rsp_ready));
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_TABLE_ENABLE;
        cfg_data  = '0;
        steady    = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom(), $urandom()};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_TABLE_ENABLE, 4'd1);
        write_reg(REG_INDEX_BITS, 4'd12);

        // An empty slot 0 matches key zero, but only at depth zero.
        send(FN_PROBE, '0, 8'd0, '0);
        send(FN_PROBE, '0, 8'd1, '0);
        send(FN_STORE, KEY_ALL, 8'd200, PAY_ALL);
        send(FN_PROBE, KEY_ALL, 8'd255, '0);
        send(FN_PROBE, KEY_ALL, 8'd200, '0);
        // A shallower store of the same key must not replace the entry.
        send(FN_STORE, KEY_ALL, 8'd100, 48'h1234_5678_9ABC);
        send(FN_STORE, KEY_ALL, 8'd255, 48'hA5A5_5A5A_A5A5);
        send(FN_PROBE, KEY_ALL, 8'd255, PAY_ALL);
        // A different key on an occupied slot is turned away.
        send(FN_STORE, KEY_ALIAS, 8'd255, 48'h0F0F_0F0F_0F0F);
        send(FN_PROBE, KEY_ALIAS, 8'd0, '0);
        // Storing key zero fills the slot but leaves it counted as empty.
        send(FN_STORE, '0, 8'd7, 48'h0000_0000_0042);
        send(FN_PROBE, '0, 8'd7, '0);
        send(FN_STORE, KEY_LOW, 8'd9, 48'h8000_0000_0001);
        send(FN_PROBE, KEY_LOW, 8'd0, '0);
        send(FN_UNUSED, KEY_ALL, 8'd255, PAY_ALL);
        send(FN_CLEAR, '0, 8'd0, '0);
        send(FN_PROBE, KEY_ALL, 8'd0, '0);
        drain();

        // With the table off nothing is stored, found or cleared.
        write_reg(REG_TABLE_ENABLE, 4'd0);
        send(FN_PROBE, '0, 8'd0, '0);
        send(FN_STORE, KEY_ALL, 8'd50, PAY_ALL);
        send(FN_PROBE, KEY_ALL, 8'd0, '0);
        send(FN_CLEAR, '0, 8'd0, '0);
        drain();

        // A single slot: every key lands on slot 0.
        write_reg(REG_TABLE_ENABLE, 4'd1);
        write_reg(REG_INDEX_BITS, 4'd0);
        send(FN_STORE, KEY_ALL, 8'd30, PAY_ALL);
        send(FN_PROBE, KEY_ALIAS, 8'd0, '0);
        send(FN_STORE, KEY_ALIAS, 8'd255, '0);
        send(FN_PROBE, KEY_ALL, 8'd30, '0);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            steady = ($urandom_range(0, 3) == 0);
            write_reg(REG_TABLE_ENABLE, CFG_WIDTH'(phase_enable[ph]));
            write_reg(REG_INDEX_BITS, CFG_WIDTH'(phase_bits[ph]));
            random_requests(phase_enable[ph] != 0 ? 160 : 40);
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ttdp_pkg.sv
src/ttdp_slot_ram.sv
src/transposition_table_depth_preferred.sv
bench/ttdp_checker.sv
bench/tb.sv
